// File: design/swcd_pkg.sv
// Shared types, constants and CRC helpers for the sensor word CRC deframer.
// No dependencies; used by every module of the block.
package swcd_pkg;

  localparam logic [7:0]  CRC_START   = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [10:0] STATUS_MASK = 11'h7FF;

  localparam logic [1:0] KIND_SERIAL = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_MEAS   = 2'd2;

  localparam logic [1:0] WORD_TEMP = 2'd1;
  localparam logic [1:0] WORD_HUM  = 2'd2;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned FULL_SCALE  = 65535;
  localparam int unsigned TEMP_GAIN   = 17500;
  localparam int unsigned HUM_GAIN    = 10000;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned PROD_W      = 31;
  localparam int unsigned GAIN_W      = 15;
  localparam int unsigned REM_W       = 18;

  // one assembled word, as handed from front to back
  typedef struct packed {
    logic [15:0] word_value;
    logic [1:0]  word_index;
    logic        crc_ok;
    logic        frame_ok;
    logic        last_word;
    logic [1:0]  kind;
  } swcd_word_t;

  typedef struct packed {
    logic empty;
    logic full;
  } swcd_qstat_t;

  // MSB-first CRC-8 update over one byte
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [1:0] words_for_kind(input logic [1:0] kind);
    logic [1:0] n;
    case (kind)
      KIND_SERIAL: n = 2'd3;
      KIND_STATUS: n = 2'd1;
      KIND_MEAS:   n = 2'd3;
      default:     n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// File: design/swcd_front.sv
// Front end: takes response bytes, tracks word phase and CRC, and pushes
// one record per completed word into the queue. Depends on swcd_pkg.
module swcd_front import swcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  input  logic       in_first_byte,
  input  logic [1:0] in_response_kind,
  output logic       q_push,
  output swcd_word_t q_wdata,
  input  swcd_qstat_t q_stat
);

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic       good_r, good_nxt;
  logic [1:0] kind_r, kind_nxt;

  logic       accept;
  logic [1:0] phase_eff, count_eff, total;
  logic [7:0] crc_eff, crc_upd;
  logic       good_eff, active, crc_match;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  always_comb begin
    // a first byte restarts the response before the byte is used
    phase_eff = in_first_byte ? 2'd0 : phase_r;
    count_eff = in_first_byte ? 2'd0 : count_r;
    crc_eff   = in_first_byte ? CRC_START : crc_r;
    good_eff  = in_first_byte ? 1'b1 : good_r;
    kind_nxt  = in_first_byte ? in_response_kind : kind_r;
    total     = words_for_kind(kind_nxt);
    active    = count_eff < total;
    crc_upd   = crc8_feed(crc_eff, in_rx_byte);
    crc_match = crc_eff == in_rx_byte;

    phase_nxt = phase_eff;
    count_nxt = count_eff;
    crc_nxt   = crc_eff;
    good_nxt  = good_eff;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    q_push    = 1'b0;

    q_wdata.word_value = {hi_r, lo_r};
    q_wdata.word_index = count_eff;
    q_wdata.crc_ok     = crc_match;
    q_wdata.frame_ok   = good_eff && crc_match;
    q_wdata.last_word  = (count_eff + 2'd1) == total;
    q_wdata.kind       = kind_nxt;

    if (active) begin
      case (phase_eff)
        2'd0: begin
          hi_nxt    = in_rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = 2'd1;
        end
        2'd1: begin
          lo_nxt    = in_rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = 2'd2;
        end
        default: begin
          q_push    = accept;
          good_nxt  = good_eff && crc_match;
          count_nxt = count_eff + 2'd1;
          crc_nxt   = CRC_START;
          phase_nxt = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      count_r <= 2'd0;
      crc_r   <= CRC_START;
      good_r  <= 1'b1;
      kind_r  <= KIND_SERIAL;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      good_r  <= good_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

endmodule

// File: design/swcd_queue.sv
// Short register queue of word records between front and back.
// Depends on swcd_pkg.
module swcd_queue import swcd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  swcd_word_t  wdata,
  input  logic        pop,
  output swcd_word_t  rdata,
  output swcd_qstat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  swcd_word_t             mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == CNT_W'(DEPTH);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/swcd_back.sv
// Back end: decodes word records (status flag, scaled temperature and
// humidity) in a three-register pipeline ending in the output register.
// Depends on swcd_pkg.
module swcd_back import swcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  swcd_qstat_t        q_stat,
  input  swcd_word_t         q_rdata,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_word_value,
  output logic [1:0]         out_word_index,
  output logic               out_crc_ok,
  output logic               out_frame_ok,
  output logic               out_last_word,
  output logic               out_data_ready,
  output logic signed [14:0] out_scaled_value
);

  logic              advance;
  logic              s1_v_r, s2_v_r, out_v_r;
  swcd_word_t        s1_rec_r, s2_rec_r, out_rec_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [15:0]       s2_q_r;
  logic [REM_W-1:0]  s2_rem_r;
  logic              s2_neg_r;
  logic              out_ready_r;
  logic [14:0]       out_scaled_r;

  logic [GAIN_W-1:0] gain;
  logic [PROD_W-1:0] prod;
  logic [31:0]       quot_sum, rem_full;
  logic [15:0]       q_est;
  logic              neg;
  logic              rem_ge;
  logic [15:0]       q_fix;
  logic [REM_W-1:0]  rem_fix;
  logic [15:0]       temp_val;
  logic [14:0]       scaled;
  logic              ready_flag;

  // whole pipeline moves together whenever the output slot frees up
  assign advance = !out_v_r || out_pop;
  assign q_pop   = advance && !q_stat.empty;

  // stage 1: constant-gain multiply
  assign gain = (q_rdata.word_index == WORD_TEMP) ? GAIN_W'(TEMP_GAIN) : GAIN_W'(HUM_GAIN);
  assign prod = PROD_W'(q_rdata.word_value) * PROD_W'(gain);

  // stage 2: divide by 65535 via x/65536*(1+1/65535); estimate is low by at most one
  assign quot_sum = 32'(s1_prod_r) + 32'(s1_prod_r >> 16);
  assign q_est    = quot_sum[31:16];
  assign rem_full = 32'(s1_prod_r) - {q_est, 16'h0000} + 32'(q_est);
  assign neg      = s1_prod_r < PROD_W'(TEMP_OFFSET * FULL_SCALE);

  // stage 3: correct quotient, apply offset with truncation toward zero
  always_comb begin
    rem_ge   = s2_rem_r >= REM_W'(FULL_SCALE);
    q_fix    = s2_q_r + 16'(rem_ge);
    rem_fix  = rem_ge ? (s2_rem_r - REM_W'(FULL_SCALE)) : s2_rem_r;
    // negative numerator with a remainder rounds up toward zero
    temp_val = q_fix - 16'(TEMP_OFFSET) + 16'(s2_neg_r && (rem_fix != '0));
    scaled   = '0;
    if (s2_rec_r.kind == KIND_MEAS) begin
      case (s2_rec_r.word_index)
        WORD_TEMP: scaled = temp_val[14:0];
        WORD_HUM:  scaled = q_fix[14:0];
        default:   scaled = '0;
      endcase
    end
    ready_flag = (s2_rec_r.kind == KIND_STATUS) &&
                 ((s2_rec_r.word_value[10:0] & STATUS_MASK) != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= !q_stat.empty;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rec_r     <= q_rdata;
      s1_prod_r    <= prod;
      s2_rec_r     <= s1_rec_r;
      s2_q_r       <= q_est;
      s2_rem_r     <= rem_full[REM_W-1:0];
      s2_neg_r     <= neg;
      out_rec_r    <= s2_rec_r;
      out_scaled_r <= scaled;
      out_ready_r  <= ready_flag;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_word_value   = out_rec_r.word_value;
  assign out_word_index   = out_rec_r.word_index;
  assign out_crc_ok       = out_rec_r.crc_ok;
  assign out_frame_ok     = out_rec_r.frame_ok;
  assign out_last_word    = out_rec_r.last_word;
  assign out_data_ready   = out_ready_r;
  assign out_scaled_value = $signed(out_scaled_r);

endmodule

// File: design/sensor_word_crc_deframer.sv
// Sensor word CRC deframer: one byte per cycle in while in_full is low, one
// decoded word out per third byte. A word goes from its CRC byte through the
// queue and the s1, s2 and out registers. Throughput is set by the front byte
// path; the word queue absorbs output stalls. Synchronous active-low reset
// empties queue and pipeline and restarts framing (CRC 0xFF, serial kind).
module sensor_word_crc_deframer import swcd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_first_byte,
  input  logic [1:0]         in_response_kind,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_word_value,
  output logic [1:0]         out_word_index,
  output logic               out_crc_ok,
  output logic               out_frame_ok,
  output logic               out_last_word,
  output logic               out_data_ready,
  output logic signed [14:0] out_scaled_value
);

  logic        q_push, q_pop;
  swcd_word_t  q_wdata, q_rdata;
  swcd_qstat_t q_stat;

  swcd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .in_first_byte    (in_first_byte),
    .in_response_kind (in_response_kind),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .q_stat           (q_stat)
  );

  swcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  swcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_word_value   (out_word_value),
    .out_word_index   (out_word_index),
    .out_crc_ok       (out_crc_ok),
    .out_frame_ok     (out_frame_ok),
    .out_last_word    (out_last_word),
    .out_data_ready   (out_data_ready),
    .out_scaled_value (out_scaled_value)
  );

`ifndef SYNTHESIS
  a_frame_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_crc_ok) |-> !out_frame_ok)
    else $error("frame_ok set on a word with a CRC error");

  a_third_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word_index == WORD_HUM) |-> out_last_word)
    else $error("third word not marked last");

  a_ready_no_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data_ready) |-> (out_scaled_value == '0))
    else $error("status word carries a scaled value");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("word queue written while full");
`endif

endmodule
